// File: rtl/core/vmsu_pkg.sv
// Shared types and constants of the virtual machine memory and stack unit.
package vmsu_pkg;

  // Fixed field widths of the request and response channels.
  localparam int unsigned SpW       = 17;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordBytes = 4;
  localparam int unsigned BankN     = 4;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_PUSH  = 2'd2,
    FUNC_POP   = 2'd3
  } func_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_SEGFAULT = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DATA_START = 1'b0,
    CFG_HEAP_END   = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic access;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } ctrl_status_t;

endpackage

// File: rtl/core/vmsu_if.sv
// Request and response channel interfaces of the memory and stack unit.
interface vmsu_in_if import vmsu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic signed [AddrW-1:0] address;
  logic [CountW-1:0]       byte_count;
  logic [DataW-1:0]        write_data;

  modport source (output valid, func, address, byte_count, write_data, input ready);
  modport sink   (input valid, func, address, byte_count, write_data, output ready);
endinterface

interface vmsu_out_if import vmsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic [1:0]       status;
  logic [SpW-1:0]   stack_pointer;

  modport source (output valid, read_data, status, stack_pointer, input ready);
  modport sink   (input valid, read_data, status, stack_pointer, output ready);
endinterface

// File: rtl/core/vmsu_ram.sv
// Generic single-port RAM with registered read data.
module vmsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one entry per enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/vmsu_datapath.sv
// Datapath: request registers, bounds checks, stack pointer, four byte banks, response register.
module vmsu_datapath import vmsu_pkg::*; #(
  parameter int unsigned MemBytes  = 65536,
  parameter int unsigned CodeStart = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SpW-1:0]     cfg_wdata_i,
  input  logic [1:0]         func_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic [CountW-1:0]  byte_count_i,
  input  logic [DataW-1:0]   write_data_i,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  output logic [DataW-1:0]   read_data_o,
  output logic [1:0]         status_code_o,
  output logic [SpW-1:0]     stack_pointer_o
);

  localparam int unsigned MemAw = $clog2(MemBytes);
  localparam int unsigned RowW  = MemAw - 2;
  localparam int unsigned Depth = (MemBytes + 3) / 4;
  localparam int unsigned ExtW  = AddrW + 2;
  localparam logic [SpW-1:0]    SpReset   = SpW'(MemBytes);
  localparam logic [SpW-1:0]    SpStep    = SpW'(WordBytes);
  localparam logic [ExtW-1:0]   MemLimit  = ExtW'(MemBytes);
  localparam logic [ExtW-1:0]   CodeLow   = ExtW'(CodeStart);
  localparam logic [CountW-1:0] WordCount = CountW'(WordBytes);
  localparam logic [RowW-1:0]   LastRow   = RowW'(Depth - 1);

  // Configuration and stack pointer registers.
  logic [SpW-1:0] data_start_q, data_start_d;
  logic [SpW-1:0] heap_end_q, heap_end_d;
  logic [SpW-1:0] sp_q, sp_d;

  // Captured request.
  func_e             func_q;
  logic [AddrW-1:0]  addr_q;
  logic [CountW-1:0] count_q;
  logic [DataW-1:0]  wdata_q;

  // Clearing pass row counter.
  logic [RowW-1:0] clr_row_q, clr_row_d;

  // Access stage results.
  logic [ExtW-1:0]   eff;
  logic [ExtW-1:0]   span_end;
  logic [CountW-1:0] cnt_eff;
  logic              span_ok;
  logic              seg_hit;
  logic              overflow;
  logic [SpW-1:0]    sp_lowered;
  logic              do_write;
  logic              do_read;
  status_e           acc_status;
  logic [1:0]        acc_off;
  logic [RowW-1:0]   acc_row;

  // Registered access results used when the read data returns.
  logic              rd_en_q;
  logic [1:0]        rd_off_q;
  logic [CountW-1:0] rd_cnt_q;
  status_e           acc_status_q;

  // Response register.
  logic [DataW-1:0] read_data_q;
  logic [1:0]       status_code_q;
  logic [SpW-1:0]   stack_pointer_q;

  logic [ByteW-1:0] bank_rdata [BankN];
  logic [DataW-1:0] rd_word;

  // Configuration writes.
  always_comb begin
    data_start_d = data_start_q;
    heap_end_d   = heap_end_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DATA_START: data_start_d = cfg_wdata_i;
        CFG_HEAP_END:   heap_end_d   = cfg_wdata_i;
        default: begin
          data_start_d = data_start_q;
          heap_end_d   = heap_end_q;
        end
      endcase
    end
  end

  // Push lowers the pointer by one word; it overflows when the result would reach the heap.
  assign sp_lowered = sp_q - SpStep;
  assign overflow   = ({1'b0, sp_q} <= ({1'b0, heap_end_q} + {1'b0, SpStep}));

  // Effective byte address and length of the access.
  always_comb begin
    case (func_q)
      FUNC_READ, FUNC_WRITE: begin
        eff     = {{2{addr_q[AddrW-1]}}, addr_q};
        cnt_eff = count_q;
      end
      FUNC_PUSH: begin
        eff     = ExtW'(sp_lowered);
        cnt_eff = WordCount;
      end
      default: begin
        eff     = ExtW'(sp_q);
        cnt_eff = WordCount;
      end
    endcase
  end

  // Bounds check and the write-protected code region.
  assign span_end = eff + ExtW'(cnt_eff);
  assign span_ok  = (cnt_eff <= WordCount) && !eff[ExtW-1] && (eff < MemLimit) &&
                    (span_end <= MemLimit);
  assign seg_hit  = (eff >= CodeLow) && (eff < ExtW'(data_start_q));
  assign acc_off  = eff[1:0];
  assign acc_row  = eff[MemAw-1:2];

  // Status of the operation and the resulting bank accesses.
  always_comb begin
    acc_status = ST_OK;
    do_write   = 1'b0;
    do_read    = 1'b0;
    sp_d       = sp_q;
    case (func_q)
      FUNC_READ: begin
        acc_status = span_ok ? ST_OK : ST_INVALID;
        do_read    = span_ok;
      end
      FUNC_WRITE: begin
        if (!span_ok) begin
          acc_status = ST_INVALID;
        end else if (seg_hit) begin
          acc_status = ST_SEGFAULT;
        end else begin
          do_write = 1'b1;
        end
      end
      FUNC_PUSH: begin
        if (overflow) begin
          acc_status = ST_OVERFLOW;
        end else begin
          sp_d = sp_lowered;
          if (!span_ok) begin
            acc_status = ST_INVALID;
          end else if (seg_hit) begin
            acc_status = ST_SEGFAULT;
          end else begin
            do_write = 1'b1;
          end
        end
      end
      default: begin
        acc_status = span_ok ? ST_OK : ST_INVALID;
        do_read    = span_ok;
        if (span_ok) begin
          sp_d = sp_q + SpStep;
        end
      end
    endcase
    if (!cmd_i.access) begin
      sp_d = sp_q;
    end
  end

  // Clearing pass counter.
  assign clr_row_d           = cmd_i.clear ? clr_row_q + RowW'(1) : clr_row_q;
  assign status_o.clear_last = (clr_row_q == LastRow);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
      heap_end_q   <= '0;
      sp_q         <= SpReset;
      clr_row_q    <= '0;
    end else begin
      data_start_q <= data_start_d;
      heap_end_q   <= heap_end_d;
      sp_q         <= sp_d;
      clr_row_q    <= clr_row_d;
    end
  end

  // Request capture and access stage payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(func_i);
      addr_q  <= address_i;
      count_q <= byte_count_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.access) begin
      rd_en_q      <= do_read;
      rd_off_q     <= acc_off;
      rd_cnt_q     <= cnt_eff;
      acc_status_q <= acc_status;
    end
  end

  // One byte bank per address lane; an access that crosses a row uses the next row in low lanes.
  for (genvar k = 0; k < BankN; k++) begin : g_bank
    logic [1:0]       lane_off;
    logic [1:0]       lane_sel;
    logic             wrap;
    logic [RowW-1:0]  row_acc;
    logic [RowW-1:0]  row_sel;
    logic             bank_en;
    logic             bank_we;
    logic [ByteW-1:0] bank_wdata;

    assign lane_off   = 2'(k) - acc_off;
    assign lane_sel   = 2'(cnt_eff - CountW'(1)) - lane_off;
    assign wrap       = (2'(k) < acc_off);
    assign row_acc    = acc_row + RowW'(wrap);
    assign row_sel    = cmd_i.clear ? clr_row_q : row_acc;
    assign bank_en    = cmd_i.clear || cmd_i.access;
    assign bank_we    = cmd_i.clear ||
                        (cmd_i.access && do_write && ({1'b0, lane_off} < cnt_eff));
    assign bank_wdata = cmd_i.clear ? '0 : wdata_q[{lane_sel, 3'b000} +: ByteW];

    vmsu_ram #(
      .Width (ByteW),
      .Depth (Depth)
    ) u_bank (
      .clk_i   (clk_i),
      .en_i    (bank_en),
      .we_i    (bank_we),
      .addr_i  (row_sel),
      .wdata_i (bank_wdata),
      .rdata_o (bank_rdata[k])
    );
  end

  // Gather the read bytes big-endian and right-aligned.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < WordBytes; i++) begin
      if (CountW'(i) < rd_cnt_q) begin
        rd_word[{2'(rd_cnt_q - CountW'(i) - CountW'(1)), 3'b000} +: ByteW] =
          bank_rdata[2'(rd_off_q + 2'(i))];
      end
    end
  end

  // Response register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_q     <= rd_en_q ? rd_word : '0;
      status_code_q   <= acc_status_q;
      stack_pointer_q <= sp_q;
    end
  end

  assign read_data_o     = read_data_q;
  assign status_code_o   = status_code_q;
  assign stack_pointer_o = stack_pointer_q;

endmodule

// File: rtl/core/vmsu_ctrl.sv
// Controller: clearing pass, request sequencing and response handshake.
module vmsu_ctrl import vmsu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StAccess = 2'd2;
  localparam logic [1:0] StDone   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Command decode.
  assign in_ready_o    = (state_q == StIdle);
  assign out_free      = !out_valid_q || out_ready_i;
  assign cmd_o.clear   = (state_q == StClear);
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.access  = (state_q == StAccess);
  assign cmd_o.load_out = (state_q == StDone) && out_free;

  // State transitions.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:  if (status_i.clear_last) state_d = StIdle;
      StIdle:   if (cmd_o.capture) state_d = StAccess;
      StAccess: state_d = StDone;
      StDone:   if (cmd_o.load_out) state_d = StIdle;
      default:  state_d = StClear;
    endcase
  end

  // Response valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/vm_memory_stack_unit.sv
// Top level of the virtual machine memory and stack unit.
//
//   Channel  Direction  Payload                                  Handshake
//   in_i     sink       func, address, byte_count, write_data    valid / ready
//   out_o    source     read_data, status, stack_pointer         valid / ready
//   cfg      write      cfg_we_i, cfg_index_i, cfg_wdata_i       write enable only
//
// Each request passes through capture, a single access of the four byte banks, and the
// response register load. After reset the banks are cleared one row per cycle; no request
// is taken during that pass, configuration writes are. A stalled response holds the
// datapath in its last step; a new request may be accepted while the previous response
// waits to be taken.
module vm_memory_stack_unit import vmsu_pkg::*; #(
  parameter int unsigned MEM_BYTES  = 65536,
  parameter int unsigned CODE_START = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SpW-1:0]     cfg_wdata_i,
  vmsu_in_if.sink            in_i,
  vmsu_out_if.source         out_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t dp_status;

  // Sequencing and handshakes.
  vmsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Checks, stack pointer and memory banks.
  vmsu_datapath #(
    .MemBytes  (MEM_BYTES),
    .CodeStart (CODE_START)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (in_i.func),
    .address_i       (in_i.address),
    .byte_count_i    (in_i.byte_count),
    .write_data_i    (in_i.write_data),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .read_data_o     (out_o.read_data),
    .status_code_o   (out_o.status),
    .stack_pointer_o (out_o.stack_pointer)
  );

endmodule

// File: rtl/core/vmsu_checker.sv
// Port-level checker of the memory and stack unit, bound to the top level.
module vmsu_checker import vmsu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [DataW-1:0] read_data_i,
  input logic [1:0]       status_i,
  input logic [SpW-1:0]   stack_pointer_i
);

  localparam logic [SpW-1:0] SpStep = SpW'(WordBytes);

  logic           out_acc;
  logic           have_prev_q;
  logic [SpW-1:0] prev_sp_q;
  logic [SpW-1:0] prev_dn;
  logic [SpW-1:0] prev_up;
  logic           in_acc;

  assign out_acc = out_valid_i && out_ready_i;
  assign in_acc  = in_valid_i && in_ready_i;
  assign prev_dn = prev_sp_q - SpStep;
  assign prev_up = prev_sp_q + SpStep;

  // Remember the stack pointer of the last delivered response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_sp_q   <= '0;
    end else if (out_acc) begin
      have_prev_q <= 1'b1;
      prev_sp_q   <= stack_pointer_i;
    end
  end

  // No request is taken in the cycle after reset: the clearing pass runs first.
  a_no_request_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !in_acc)
    else $error("request accepted right after reset");

  // A stalled response stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response withdrawn while stalled");

  // Failed operations return no data.
  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (read_data_i == '0))
    else $error("nonzero read data on an error response");

  // The stack pointer moves by at most one word between responses.
  a_sp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_prev_q |->
      (stack_pointer_i == prev_sp_q) || (stack_pointer_i == prev_dn) ||
      (stack_pointer_i == prev_up))
    else $error("stack pointer jumped by more than one word");

  // A stack overflow leaves the pointer where it was.
  a_overflow_keeps_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_prev_q && (status_i == ST_OVERFLOW) |-> (stack_pointer_i == prev_sp_q))
    else $error("stack pointer changed on overflow");

endmodule

bind vm_memory_stack_unit vmsu_checker u_vmsu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .read_data_i     (out_o.read_data),
  .status_i        (out_o.status),
  .stack_pointer_i (out_o.stack_pointer)
);

// File: dv/tb_vm_memory_stack_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the memory and stack unit with a shadow memory predictor.
module tb_vm_memory_stack_unit;
  import vmsu_pkg::*;

  localparam int MemBytes   = 65536;
  localparam int CodeStart  = 256;
  localparam int CycleLimit = 300000;
  localparam int LongHold   = 150;
  localparam int MaxReports = 10;

  typedef struct packed {
    func_e             func;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] byte_count;
    logic [DataW-1:0]  write_data;
  } mem_req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    status_e          status;
    logic [SpW-1:0]   stack_pointer;
  } mem_rsp_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b1;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SpW-1:0]     cfg_wdata_i = '0;

  vmsu_in_if  req_if ();
  vmsu_out_if rsp_if ();

  vm_memory_stack_unit #(
    .MEM_BYTES (MemBytes),
    .CODE_START(CodeStart)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // Shadow copy of the memory, the stack pointer and the two registers.
  logic [ByteW-1:0] shadow_mem [MemBytes];
  logic [SpW-1:0]   shadow_sp;
  logic [SpW-1:0]   data_start_q;
  logic [SpW-1:0]   heap_end_q;

  mem_req_t request_q [$];
  mem_rsp_t expected_rsp_q [$];

  int send_gap_max;
  int take_stall_max;
  int backpressure_left;
  int error_count;
  int requests_sent;
  int responses_checked;
  int cycle_count;
  int op_count [4];
  int status_count [4];

  always #1 clk_i = ~clk_i;

  // An access fits when it has at most four bytes and lies wholly inside memory.
  function automatic bit span_fits(input longint addr, input int unsigned cnt);
    return cnt <= WordBytes && addr >= 0 && addr < MemBytes &&
           addr + longint'(cnt) <= MemBytes;
  endfunction

  function automatic status_e load_bytes(input longint addr, input int unsigned cnt,
                                         output logic [DataW-1:0] data);
    data = '0;
    if (!span_fits(addr, cnt)) return ST_INVALID;
    for (int unsigned i = 0; i < cnt; i++) begin
      data = (data << ByteW) | DataW'(shadow_mem[int'(addr) + i]);
    end
    return ST_OK;
  endfunction

  // Writes the low cnt bytes, most significant first; the code region is protected.
  function automatic status_e store_bytes(input longint addr, input int unsigned cnt,
                                          input logic [DataW-1:0] value);
    if (!span_fits(addr, cnt)) return ST_INVALID;
    if (addr >= CodeStart && addr < longint'(data_start_q)) return ST_SEGFAULT;
    for (int unsigned i = 0; i < cnt; i++) begin
      shadow_mem[int'(addr) + i] = ByteW'(value >> ((cnt - 1 - i) * ByteW));
    end
    return ST_OK;
  endfunction

  // Applies one request to the shadow state and returns the response it must give.
  function automatic mem_rsp_t predict_access(input mem_req_t r);
    mem_rsp_t rsp;
    longint   lowered;
    rsp = '0;
    case (r.func)
      FUNC_READ: begin
        rsp.status = load_bytes(longint'($signed(r.address)), r.byte_count, rsp.read_data);
      end
      FUNC_WRITE: begin
        rsp.status = store_bytes(longint'($signed(r.address)), r.byte_count, r.write_data);
      end
      FUNC_PUSH: begin
        // An overflowing push leaves the pointer alone; a refused store keeps it lowered.
        lowered = longint'(shadow_sp) - WordBytes;
        if (lowered <= longint'(heap_end_q)) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          shadow_sp  = lowered[SpW-1:0];
          rsp.status = store_bytes(longint'(shadow_sp), WordBytes, r.write_data);
        end
      end
      default: begin
        rsp.status = load_bytes(longint'(shadow_sp), WordBytes, rsp.read_data);
        if (rsp.status == ST_OK) shadow_sp = shadow_sp + SpW'(WordBytes);
        else rsp.status = ST_INVALID;
      end
    endcase
    rsp.stack_pointer = shadow_sp;
    return rsp;
  endfunction

  // Address mix: stack area, region borders, low data area and out-of-range values.
  function automatic logic [AddrW-1:0] pick_address();
    case ($urandom_range(0, 9))
      0:       pick_address = $urandom();
      1:       pick_address = -$urandom_range(1, 8);
      2:       pick_address = MemBytes - $urandom_range(0, 6);
      3:       pick_address = CodeStart - 4 + $urandom_range(0, 8);
      4:       pick_address = data_start_q - 4 + $urandom_range(0, 8);
      5, 6:    pick_address = MemBytes - $urandom_range(1, 512);
      default: pick_address = $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic queue_request(input func_e f, input logic [AddrW-1:0] addr,
                               input int unsigned cnt, input logic [DataW-1:0] data);
    mem_req_t r;
    r.func       = f;
    r.address    = addr;
    r.byte_count = CountW'(cnt);
    r.write_data = data;
    request_q.push_back(r);
  endtask

  // Mostly legal byte counts; now and then zero or one of the oversize counts.
  task automatic random_phase(input int n, input int push_pct, input int pop_pct);
    int          pick;
    int unsigned cnt;
    func_e       f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) f = FUNC_PUSH;
      else if (pick < push_pct + pop_pct) f = FUNC_POP;
      else if (pick[0]) f = FUNC_READ;
      else f = FUNC_WRITE;
      cnt = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      queue_request(f, pick_address(), cnt, $urandom());
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= SpW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_DATA_START) data_start_q = SpW'(value);
    else heap_end_q = SpW'(value);
  endtask

  // Every queued request has been taken and every response has come back.
  task automatic wait_drained();
    while (request_q.size() != 0 || expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver: offers queued requests with a random gap after each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    mem_req_t taken;
    mem_rsp_t want;
    int       send_gap;
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.func       <= FUNC_READ;
      req_if.address    <= '0;
      req_if.byte_count <= '0;
      req_if.write_data <= '0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken.func       = func_e'(req_if.func);
        taken.address    = req_if.address;
        taken.byte_count = req_if.byte_count;
        taken.write_data = req_if.write_data;
        want = predict_access(taken);
        expected_rsp_q.push_back(want);
        void'(request_q.pop_front());
        op_count[int'(taken.func)]++;
        status_count[int'(want.status)]++;
        requests_sent++;
        send_gap = $urandom_range(0, send_gap_max);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          req_if.valid      <= 1'b1;
          req_if.func       <= request_q[0].func;
          req_if.address    <= request_q[0].address;
          req_if.byte_count <= request_q[0].byte_count;
          req_if.write_data <= request_q[0].write_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each response with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_responses
    mem_rsp_t want;
    int       take_stall;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        responses_checked++;
        if (expected_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("Unexpected response: data %h status %0d sp %h",
                     rsp_if.read_data, rsp_if.status, rsp_if.stack_pointer);
          end
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_if.read_data !== want.read_data || rsp_if.status !== want.status ||
              rsp_if.stack_pointer !== want.stack_pointer) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("Response %0d mismatch: expected data %h status %0d sp %h, got data %h status %0d sp %h",
                       responses_checked, want.read_data, want.status, want.stack_pointer,
                       rsp_if.read_data, rsp_if.status, rsp_if.stack_pointer);
            end
          end
        end
        take_stall = $urandom_range(0, take_stall_max);
      end else if (take_stall > 0) begin
        take_stall--;
      end
      rsp_if.ready <= (take_stall == 0) && (backpressure_left == 0);
    end
  end

  // Long receiver hold-offs while requests keep coming, so the unit backs up.
  always @(posedge clk_i or negedge rst_ni) begin : hold_responses
    int results_noted;
    int holds_done;
    if (!rst_ni) begin
      backpressure_left <= 0;
      results_noted = 0;
      holds_done    = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) results_noted++;
      if (backpressure_left > 0) begin
        backpressure_left <= backpressure_left - 1;
      end else if (holds_done < 2 && req_if.valid &&
                   results_noted >= 300 + 400 * holds_done) begin
        backpressure_left <= LongHold;
        holds_done++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run did not finish within %0d cycles", CycleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int floor_addr;
    rst_ni <= 1'b0;
    for (int a = 0; a < MemBytes; a++) shadow_mem[a] = '0;
    shadow_sp      = SpW'(MemBytes);
    data_start_q   = '0;
    heap_end_q     = '0;
    send_gap_max   = 5;
    take_stall_max = 5;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bounds, byte counts, byte order and the protected code region.
    write_reg(CFG_DATA_START, 1024);
    write_reg(CFG_HEAP_END, MemBytes - 4);
    queue_request(FUNC_WRITE, 0, 4, 32'hDEAD_BEEF);
    queue_request(FUNC_READ, 0, 4, 32'hFFFF_FFFF);
    queue_request(FUNC_READ, 1, 2, 0);
    queue_request(FUNC_READ, 0, 0, 0);
    queue_request(FUNC_READ, 0, 5, 0);
    queue_request(FUNC_WRITE, 16, 7, 32'hFFFF_FFFF);
    queue_request(FUNC_READ, 32'hFFFF_FFFF, 1, 0);
    queue_request(FUNC_READ, 32'h8000_0000, 1, 0);
    queue_request(FUNC_READ, 32'h7FFF_FFFF, 4, 0);
    queue_request(FUNC_READ, MemBytes, 0, 0);
    queue_request(FUNC_WRITE, MemBytes - 4, 4, 32'hA5C3_0F96);
    queue_request(FUNC_READ, MemBytes - 4, 4, 0);
    queue_request(FUNC_READ, MemBytes - 1, 2, 0);
    queue_request(FUNC_WRITE, CodeStart - 1, 2, 32'h0000_1234);
    queue_request(FUNC_WRITE, CodeStart, 1, 32'h0000_0055);
    queue_request(FUNC_WRITE, 1023, 4, 32'h0000_0000);
    queue_request(FUNC_WRITE, 1024, 3, 32'h00AB_CDEF);
    queue_request(FUNC_WRITE, 1024, 6, 0);
    // Push runs into the heap limit; pop from an empty stack.
    queue_request(FUNC_PUSH, 0, 4, 32'h1111_1111);
    queue_request(FUNC_POP, 0, 4, 0);
    wait_drained();

    // Push refused by the protected region keeps its lowered pointer.
    write_reg(CFG_DATA_START, MemBytes);
    write_reg(CFG_HEAP_END, 0);
    queue_request(FUNC_PUSH, 0, 4, 32'h2222_2222);
    queue_request(FUNC_POP, 0, 4, 0);
    wait_drained();

    // Plain push and pop with extreme words.
    write_reg(CFG_DATA_START, 0);
    queue_request(FUNC_PUSH, 0, 4, 32'hFFFF_FFFF);
    queue_request(FUNC_PUSH, 0, 4, 32'h0000_0000);
    queue_request(FUNC_POP, 0, 4, 0);
    queue_request(FUNC_POP, 0, 4, 0);
    wait_drained();

    // Balanced random traffic, both sides idling.
    random_phase(210, 20, 20);
    wait_drained();

    // No idling; heap limit just under the stack so pushes often overflow.
    send_gap_max   = 0;
    take_stall_max = 0;
    floor_addr = int'(shadow_sp) - 4 * $urandom_range(2, 10);
    if (floor_addr < 0) floor_addr = 0;
    write_reg(CFG_DATA_START, 512);
    write_reg(CFG_HEAP_END, floor_addr);
    random_phase(210, 25, 20);
    wait_drained();

    // Everything above the code start is protected; pushes still lower the pointer.
    send_gap_max = 5;
    write_reg(CFG_DATA_START, MemBytes);
    write_reg(CFG_HEAP_END, 0);
    random_phase(150, 30, 15);
    wait_drained();

    // Push-heavy traffic grows the stack under a random layout.
    send_gap_max   = 0;
    take_stall_max = 5;
    write_reg(CFG_DATA_START, $urandom_range(0, MemBytes));
    write_reg(CFG_HEAP_END, $urandom_range(0, MemBytes / 2));
    random_phase(260, 40, 10);
    wait_drained();

    // Heap limit at the very top: every push overflows, pops unwind the stack.
    send_gap_max = 5;
    write_reg(CFG_DATA_START, CodeStart);
    write_reg(CFG_HEAP_END, MemBytes);
    random_phase(200, 5, 45);
    wait_drained();

    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests (%0d reads, %0d writes, %0d pushes, %0d pops), checked %0d responses",
             requests_sent, op_count[FUNC_READ], op_count[FUNC_WRITE], op_count[FUNC_PUSH],
             op_count[FUNC_POP], responses_checked);
    $display("Statuses: %0d ok, %0d invalid address, %0d segfault, %0d stack overflow",
             status_count[ST_OK], status_count[ST_INVALID], status_count[ST_SEGFAULT],
             status_count[ST_OVERFLOW]);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failing responses, %0d responses missing", error_count,
               expected_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/vmsu_pkg.sv
rtl/core/vmsu_if.sv
rtl/core/vmsu_ram.sv
rtl/core/vmsu_datapath.sv
rtl/core/vmsu_ctrl.sv
rtl/core/vm_memory_stack_unit.sv
rtl/core/vmsu_checker.sv
dv/tb_vm_memory_stack_unit.sv
